// ----- hw/rtl/assert_macros.svh -----
// Assertion macros shared by the RTL files of the Jaccard accuracy block.
// Self-contained; every macro takes a clock and an active-low reset.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The condition holds on every clock edge outside reset.
`define ASSERT_ALWAYS(label, clk, rst_n, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// Whenever the antecedent holds, the consequent holds on the same edge.
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

`endif

// ----- hw/rtl/jacc_pkg.sv -----
// Package for the multilabel Jaccard accuracy block: sizes, state type and popcount.
// No dependencies; imported by multilabel_jaccard_accuracy.
package jacc_pkg;

	localparam int NUM_CLASSES = 64;
	localparam int MAX_SAMPLES = 65536;

	localparam int CLASS_W     = 64;
	localparam int DIGIT_W     = 8;
	localparam int NUM_DIGITS  = CLASS_W / DIGIT_W;
	localparam int DIGIT_CNT_W = $clog2(NUM_DIGITS);
	localparam int POP_W       = $clog2(DIGIT_W + 1);
	localparam int CNT_W       = 7;
	localparam int FRAC_W      = 16;
	localparam int SCORE_W     = 17;
	localparam int SUM_W       = 33;
	localparam int COUNT_W     = 17;
	localparam int DIV_STEPS   = SCORE_W;
	localparam int STEP_W      = $clog2(DIV_STEPS);
	localparam int IN_W        = 2 * CLASS_W;
	localparam int OUT_W       = 48;

	localparam logic [CLASS_W-1:0] CLASS_MASK = (NUM_CLASSES >= CLASS_W) ?
		{CLASS_W{1'b1}} : ((64'd1 << NUM_CLASSES) - 64'd1);

	localparam logic [SCORE_W-1:0] SCORE_ONE = 17'h10000;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_COUNT,
		ST_DIV_SCORE,
		ST_ACCUM,
		ST_DIV_MEAN,
		ST_DONE
	} jacc_state_t;

	function automatic logic [POP_W-1:0] digit_popcount(input logic [DIGIT_W-1:0] d);
		logic [POP_W-1:0] n;
		n = '0;
		for (int i = 0; i < DIGIT_W; i++) begin
			n = n + POP_W'(d[i]);
		end
		return n;
	endfunction

endpackage

// ----- hw/rtl/multilabel_jaccard_accuracy.sv -----
// Multilabel Jaccard accuracy: one sample per request, per-sample score and running mean.
// Depends on jacc_pkg and assert_macros.svh.
//
// A sample is processed in full before the block can accept the next one:
// the two class bitmaps are counted 8 classes per cycle, then a shared restoring
// divider forms the 17-bit score one quotient bit per cycle, then the score is
// accumulated, the result is handed to the output register and the block returns
// to idle, where the next request is accepted.
// A sample marked last runs the same divider again for sum/count before the
// hand-over. The output register holds a finished result while the next sample
// is taken in; if that register is still full when the next result is ready, the
// block waits in its hand-over state until the receiver takes the older result.
// A sample whose two sets are both empty scores 0 and sets tuser.
`include "assert_macros.svh"

module multilabel_jaccard_accuracy import jacc_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             s_tvalid,
	output logic             s_tready,
	input  logic [IN_W-1:0]  s_tdata,  // true_set[63:0], pred_set[127:64]
	input  logic             s_tlast,  // last_sample
	output logic             m_tvalid,
	input  logic             m_tready,
	// sample_score[16:0], hit_count[23:17], union_count[30:24], mean_score[47:31]
	output logic [OUT_W-1:0] m_tdata,
	output logic             m_tuser,  // empty_sample
	output logic             m_tlast   // final_res
);

	jacc_state_t state_q, state_d;

	logic [CLASS_W-1:0]     true_sh_q, pred_sh_q;
	logic [DIGIT_CNT_W-1:0] digit_q;
	logic [CNT_W-1:0]       hits_q, uni_q, hits_d, uni_d;
	logic                   last_q, empty_q;

	logic [SCORE_W-1:0]     rem_q, div_q, quot_q, score_q;
	logic [FRAC_W:0]        low_q;
	logic [STEP_W-1:0]      step_q;
	logic [SCORE_W:0]       trial, diff;
	logic                   ge;

	logic [SUM_W-1:0]       sum_q, sum_d;
	logic [COUNT_W-1:0]     count_q, count_d;

	logic                   out_valid_q, out_empty_q, out_last_q;
	logic [OUT_W-1:0]       out_data_q;
	logic [SCORE_W-1:0]     mean_val;

	logic count_done, div_done, div_run, load_out;

	assign count_done = (digit_q == DIGIT_CNT_W'(NUM_DIGITS - 1));
	assign div_done   = (step_q == STEP_W'(DIV_STEPS - 1));

	// One digit of each bitmap per cycle.
	assign hits_d = hits_q +
		CNT_W'(digit_popcount(true_sh_q[DIGIT_W-1:0] & pred_sh_q[DIGIT_W-1:0]));
	assign uni_d  = uni_q +
		CNT_W'(digit_popcount(true_sh_q[DIGIT_W-1:0] | pred_sh_q[DIGIT_W-1:0]));

	// Restoring divider step; the partial remainder stays below the divisor after step one.
	assign trial = {rem_q, low_q[FRAC_W]};
	assign ge    = (trial >= {1'b0, div_q});
	assign diff  = trial - {1'b0, div_q};

	// Accumulate, saturating the sample count; the sum stops growing once the count saturates.
	always_comb begin
		sum_d   = sum_q;
		count_d = count_q;
		if (count_q < COUNT_W'(MAX_SAMPLES)) begin
			count_d = count_q + COUNT_W'(1);
			sum_d   = sum_q + SUM_W'(score_q);
		end
	end

	assign mean_val = last_q ? quot_q : '0;

	// Next state.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE:      if (s_tvalid) state_d = ST_COUNT;
			ST_COUNT:     if (count_done) state_d = ST_DIV_SCORE;
			ST_DIV_SCORE: if (div_done) state_d = ST_ACCUM;
			ST_ACCUM:     state_d = last_q ? ST_DIV_MEAN : ST_DONE;
			ST_DIV_MEAN:  if (div_done) state_d = ST_DONE;
			ST_DONE:      if (!out_valid_q || m_tready) state_d = ST_IDLE;
			default:      state_d = ST_IDLE;
		endcase
	end

	// Control outputs of the sequencer.
	always_comb begin
		s_tready = 1'b0;
		div_run  = 1'b0;
		load_out = 1'b0;
		unique case (state_q)
			ST_IDLE:      s_tready = 1'b1;
			ST_DIV_SCORE: div_run  = 1'b1;
			ST_DIV_MEAN:  div_run  = 1'b1;
			ST_DONE:      load_out = !out_valid_q || m_tready;
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			digit_q     <= '0;
			step_q      <= '0;
			sum_q       <= '0;
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_COUNT) begin
				digit_q <= digit_q + DIGIT_CNT_W'(1);
			end
			if (div_run) begin
				step_q <= div_done ? '0 : step_q + STEP_W'(1);
			end
			if (state_q == ST_ACCUM) begin
				sum_q   <= last_q ? '0 : sum_d;
				count_q <= last_q ? '0 : count_d;
			end
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Datapath registers.
	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			true_sh_q <= s_tdata[CLASS_W-1:0] & CLASS_MASK;
			pred_sh_q <= s_tdata[IN_W-1:CLASS_W] & CLASS_MASK;
			last_q    <= s_tlast;
			hits_q    <= '0;
			uni_q     <= '0;
		end
		if (state_q == ST_COUNT) begin
			true_sh_q <= true_sh_q >> DIGIT_W;
			pred_sh_q <= pred_sh_q >> DIGIT_W;
			hits_q    <= hits_d;
			uni_q     <= uni_d;
			if (count_done) begin
				// Dividend is hits << 16; the first step compares hits itself.
				rem_q   <= SCORE_W'(hits_d >> 1);
				low_q   <= {hits_d[0], {FRAC_W{1'b0}}};
				div_q   <= SCORE_W'(uni_d);
				empty_q <= (uni_d == '0);
			end
		end
		if (div_run) begin
			rem_q  <= ge ? diff[SCORE_W-1:0] : trial[SCORE_W-1:0];
			low_q  <= low_q << 1;
			quot_q <= {quot_q[SCORE_W-2:0], ge};
			if (state_q == ST_DIV_SCORE && div_done) begin
				score_q <= empty_q ? '0 : {quot_q[SCORE_W-2:0], ge};
			end
		end
		if (state_q == ST_ACCUM) begin
			// Mean division over the updated sum; the count includes this sample unless it has saturated.
			rem_q <= {1'b0, sum_d[SUM_W-1:FRAC_W+1]};
			low_q <= sum_d[FRAC_W:0];
			div_q <= count_d;
		end
		if (load_out) begin
			out_data_q  <= {mean_val, uni_q, hits_q, score_q};
			out_empty_q <= empty_q;
			out_last_q  <= last_q;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;
	assign m_tuser  = out_empty_q;
	assign m_tlast  = out_last_q;

	`ASSERT_ALWAYS(a_count_bound, clk, arst_n, count_q <= COUNT_W'(MAX_SAMPLES), "sample count above limit")
	`ASSERT_IMPLIES(a_score_bound, clk, arst_n, m_tvalid, (m_tdata[16:0] <= SCORE_ONE) && (m_tdata[23:17] <= m_tdata[30:24]), "score or hit count out of range")
	`ASSERT_IMPLIES(a_mean_zero, clk, arst_n, m_tvalid && !m_tlast, m_tdata[47:31] == '0, "mean given on a non-final result")
	`ASSERT_IMPLIES(a_empty, clk, arst_n, m_tvalid && m_tuser, (m_tdata[30:24] == '0) && (m_tdata[16:0] == '0), "empty sample with nonzero union or score")

endmodule
